[rtl/cna_pkg.sv]
// Shared types, op codes and saturation helpers for the complex number ALU.
`timescale 1ns / 1ps
package cna_pkg;

   localparam int DATA_W  = 32;              // operand and result width
   localparam int FRAC_W  = 16;              // fraction bits of the fixed-point format
   localparam int PROD_W  = 2 * DATA_W;      // one full product
   localparam int SUM_W   = PROD_W + 1;      // sum or difference of two products
   localparam int MULSH_W = SUM_W - FRAC_W;  // product sum after the fraction shift
   localparam int OP_W    = 4;
   localparam int CLS_W   = 3;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [OP_W-1:0] OP_ADD = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV = 4'd3;
   localparam logic [OP_W-1:0] OP_NEG = 4'd4;
   localparam logic [OP_W-1:0] OP_EQ  = 4'd5;
   localparam logic [OP_W-1:0] OP_NE  = 4'd6;
   localparam logic [OP_W-1:0] OP_LT  = 4'd7;
   localparam logic [OP_W-1:0] OP_LE  = 4'd8;
   localparam logic [OP_W-1:0] OP_GT  = 4'd9;
   localparam logic [OP_W-1:0] OP_GE  = 4'd10;

   localparam logic [CLS_W-1:0] CLS_NONE = 3'd0;
   localparam logic [CLS_W-1:0] CLS_LIN  = 3'd1;
   localparam logic [CLS_W-1:0] CLS_MUL  = 3'd2;
   localparam logic [CLS_W-1:0] CLS_DIV  = 3'd3;
   localparam logic [CLS_W-1:0] CLS_CMP  = 3'd4;

   localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] a_re;
      logic signed [DATA_W-1:0] a_im;
      logic signed [DATA_W-1:0] b_re;
      logic signed [DATA_W-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] res_re;
      logic signed [DATA_W-1:0] res_im;
      logic                     cmp_true;
      logic                     div_zero;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic [CLS_W-1:0] cls;
      req_type          req;
   } item_type;

   typedef struct packed {
      logic [PROD_W-1:0] mag_re;
      logic [PROD_W-1:0] mag_im;
      logic              neg_re;
      logic              neg_im;
      logic [PROD_W-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     sat;
   } sat_type;

   // Clip a sum one bit wider than the data width.
   function automatic sat_type sat_sum(input logic signed [DATA_W:0] v);
      sat_type r;
      r.sat = v[DATA_W] ^ v[DATA_W-1];
      if (r.sat) begin
         r.val = v[DATA_W] ? MIN_VAL : MAX_VAL;
      end else begin
         r.val = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // Clip a shifted product sum.
   function automatic sat_type sat_wide(input logic signed [MULSH_W-1:0] v);
      sat_type r;
      logic [MULSH_W-DATA_W:0] hi;
      hi = v[MULSH_W-1:DATA_W-1];
      r.sat = !((&hi) || !(|hi));
      if (r.sat) begin
         r.val = v[MULSH_W-1] ? MIN_VAL : MAX_VAL;
      end else begin
         r.val = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/cna_front.sv]
// Front end: accepts command items and classifies them by op code.
`timescale 1ns / 1ps
module cna_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  cna_pkg::req_type  req_item,
   output logic              push,
   output cna_pkg::item_type push_item
);

   logic              vld_ff, vld_in;
   cna_pkg::item_type item_ff, item_in;

   always_comb begin
      vld_in = start && !busy;
      item_in.req = req_item;
      case (req_item.op)
         cna_pkg::OP_ADD, cna_pkg::OP_SUB, cna_pkg::OP_NEG: item_in.cls = cna_pkg::CLS_LIN;
         cna_pkg::OP_MUL: item_in.cls = cna_pkg::CLS_MUL;
         cna_pkg::OP_DIV: item_in.cls = cna_pkg::CLS_DIV;
         cna_pkg::OP_EQ, cna_pkg::OP_NE, cna_pkg::OP_LT, cna_pkg::OP_LE,
         cna_pkg::OP_GT, cna_pkg::OP_GE: item_in.cls = cna_pkg::CLS_CMP;
         default: item_in.cls = cna_pkg::CLS_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (vld_in) begin
         item_ff <= item_in;
      end
   end

   assign push      = vld_ff;
   assign push_item = item_ff;

endmodule

[rtl/cna_queue.sv]
// Short item queue between the front end and the execution back end.
`timescale 1ns / 1ps
module cna_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cna_pkg::item_type push_item,
   input  logic              pop,
   output logic              valid,
   output cna_pkg::item_type head_item,
   output logic              almost_full
);

   cna_pkg::item_type             mem_ff [cna_pkg::QDEPTH];
   logic [cna_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cna_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cna_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + cna_pkg::QCNT_W'(push) - cna_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign valid       = cnt_ff != '0;
   assign head_item   = mem_ff[rd_ptr_ff];
   // Keep one slot for the item already held in the front end.
   assign almost_full = cnt_ff >= cna_pkg::QCNT_W'(cna_pkg::QDEPTH - 1);

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && cnt_ff == cna_pkg::QCNT_W'(cna_pkg::QDEPTH) |-> pop)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0)
      else $error("queue read while empty");
`endif

endmodule

[rtl/cna_div.sv]
// Radix-2 restoring divider for both parts of a complex quotient.
`timescale 1ns / 1ps
module cna_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cna_pkg::div_cmd_type cmd,
   output logic                 active,
   output logic                 done,
   output cna_pkg::rsp_type     rsp
);

   localparam int HI_SH = cna_pkg::DATA_W - cna_pkg::FRAC_W;
   localparam int CNT_W = $clog2(cna_pkg::DATA_W + 2);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(cna_pkg::DATA_W + 1);

   logic                          active_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [cna_pkg::PROD_W-1:0]    den_ff;
   logic [cna_pkg::PROD_W-1:0]    rem_ff [2];
   logic [cna_pkg::DATA_W-1:0]    low_ff [2];
   logic [cna_pkg::DATA_W-1:0]    quo_ff [2];
   logic                          neg_ff [2];
   logic                          ovf_ff [2];
   logic [cna_pkg::PROD_W:0]      trial  [2];
   logic                          fits   [2];
   cna_pkg::sat_type              fin    [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         trial[l] = {rem_ff[l], low_ff[l][cna_pkg::DATA_W-1]};
         fits[l]  = trial[l] >= {1'b0, den_ff};
         if (ovf_ff[l]) begin
            fin[l].sat = 1'b1;
            fin[l].val = neg_ff[l] ? cna_pkg::MIN_VAL : cna_pkg::MAX_VAL;
         end else if (neg_ff[l]) begin
            fin[l].sat = quo_ff[l][cna_pkg::DATA_W-1] && (|quo_ff[l][cna_pkg::DATA_W-2:0]);
            fin[l].val = fin[l].sat ? cna_pkg::MIN_VAL : -quo_ff[l];
         end else begin
            fin[l].sat = quo_ff[l][cna_pkg::DATA_W-1];
            fin[l].val = fin[l].sat ? cna_pkg::MAX_VAL : quo_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (start) begin
         active_ff <= 1'b1;
      end else if (active_ff && cnt_ff == LAST) begin
         active_ff <= 1'b0;
      end
      if (start) begin
         cnt_ff    <= '0;
         den_ff    <= cmd.den;
         rem_ff[0] <= cmd.mag_re;
         rem_ff[1] <= cmd.mag_im;
         neg_ff[0] <= cmd.neg_re;
         neg_ff[1] <= cmd.neg_im;
      end else if (active_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         for (int l = 0; l < 2; l++) begin
            if (cnt_ff == '0) begin
               // Split the scaled numerator: high part seeds the remainder.
               ovf_ff[l] <= (rem_ff[l] >> HI_SH) >= den_ff;
               rem_ff[l] <= rem_ff[l] >> HI_SH;
               low_ff[l] <= {rem_ff[l][HI_SH-1:0], {cna_pkg::FRAC_W{1'b0}}};
               quo_ff[l] <= '0;
            end else if (cnt_ff != LAST) begin
               rem_ff[l] <= fits[l] ? cna_pkg::PROD_W'(trial[l] - {1'b0, den_ff})
                                    : trial[l][cna_pkg::PROD_W-1:0];
               low_ff[l] <= {low_ff[l][cna_pkg::DATA_W-2:0], 1'b0};
               quo_ff[l] <= {quo_ff[l][cna_pkg::DATA_W-2:0], fits[l]};
            end
         end
      end
   end

   assign active        = active_ff;
   assign done          = active_ff && cnt_ff == LAST;
   assign rsp.res_re    = fin[0].val;
   assign rsp.res_im    = fin[1].val;
   assign rsp.cmp_true  = 1'b0;
   assign rsp.div_zero  = 1'b0;
   assign rsp.saturated = fin[0].sat || fin[1].sat;

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !active_ff)
      else $error("divider launched while running");
`endif

endmodule

[rtl/cna_back.sv]
// Back end: products, sums, compares and result register; hands divides to the divider.
`timescale 1ns / 1ps
module cna_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  cna_pkg::item_type    q_item,
   output logic                 q_pop,
   output logic                 div_start,
   output cna_pkg::div_cmd_type div_cmd,
   input  logic                 div_active,
   input  logic                 div_done,
   input  cna_pkg::rsp_type     div_rsp,
   output logic                 rsp_strobe,
   output cna_pkg::rsp_type     rsp_item
);

   localparam int DW = cna_pkg::DATA_W;
   localparam int PW = cna_pkg::PROD_W;
   localparam int SW = cna_pkg::SUM_W;

   logic                    p_vld_ff;
   cna_pkg::item_type       p_item_ff;
   logic signed [PW-1:0]    rr_ff, ii_ff, ir_ff, ri_ff;
   logic signed [PW-1:0]    aar_ff, aai_ff, bbr_ff, bbi_ff;

   logic                    adv;
   logic signed [SW-1:0]    x_mul, y_mul, x_div, y_div;
   logic [PW-1:0]           ma, mb;
   logic signed [DW:0]      ar, ai, br, bi, lin_re, lin_im;
   cna_pkg::sat_type        s_re, s_im;
   logic                    eq, cmp;
   cna_pkg::rsp_type        s_rsp;
   logic                    s_div;
   logic                    emit;
   logic                    rsp_strobe_ff;
   cna_pkg::rsp_type        rsp_ff;

   assign adv   = !div_active;
   assign q_pop = adv && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (adv) begin
         p_vld_ff <= q_valid;
      end
      if (q_pop) begin
         p_item_ff <= q_item;
         rr_ff     <= q_item.req.a_re * q_item.req.b_re;
         ii_ff     <= q_item.req.a_im * q_item.req.b_im;
         ir_ff     <= q_item.req.a_im * q_item.req.b_re;
         ri_ff     <= q_item.req.a_re * q_item.req.b_im;
         aar_ff    <= q_item.req.a_re * q_item.req.a_re;
         aai_ff    <= q_item.req.a_im * q_item.req.a_im;
         bbr_ff    <= q_item.req.b_re * q_item.req.b_re;
         bbi_ff    <= q_item.req.b_im * q_item.req.b_im;
      end
   end

   always_comb begin
      ar = {p_item_ff.req.a_re[DW-1], p_item_ff.req.a_re};
      ai = {p_item_ff.req.a_im[DW-1], p_item_ff.req.a_im};
      br = {p_item_ff.req.b_re[DW-1], p_item_ff.req.b_re};
      bi = {p_item_ff.req.b_im[DW-1], p_item_ff.req.b_im};
      x_mul = {rr_ff[PW-1], rr_ff} - {ii_ff[PW-1], ii_ff};
      y_mul = {ir_ff[PW-1], ir_ff} + {ri_ff[PW-1], ri_ff};
      x_div = {rr_ff[PW-1], rr_ff} + {ii_ff[PW-1], ii_ff};
      y_div = {ir_ff[PW-1], ir_ff} - {ri_ff[PW-1], ri_ff};
      ma    = PW'($unsigned(aar_ff) + $unsigned(aai_ff));
      mb    = PW'($unsigned(bbr_ff) + $unsigned(bbi_ff));
      eq    = (ar == br) && (ai == bi);

      case (p_item_ff.req.op)
         cna_pkg::OP_SUB: begin
            lin_re = ar - br;
            lin_im = ai - bi;
         end
         cna_pkg::OP_NEG: begin
            lin_re = -ar;
            lin_im = -ai;
         end
         default: begin
            lin_re = ar + br;
            lin_im = ai + bi;
         end
      endcase

      case (p_item_ff.req.op)
         cna_pkg::OP_EQ: cmp = eq;
         cna_pkg::OP_NE: cmp = !eq;
         cna_pkg::OP_LT: cmp = ma < mb;
         cna_pkg::OP_LE: cmp = (ma < mb) || eq;
         cna_pkg::OP_GT: cmp = ma > mb;
         cna_pkg::OP_GE: cmp = (ma > mb) || eq;
         default:        cmp = 1'b0;
      endcase

      s_rsp = '0;
      s_div = 1'b0;
      s_re  = cna_pkg::sat_sum(lin_re);
      s_im  = cna_pkg::sat_sum(lin_im);
      case (p_item_ff.cls)
         cna_pkg::CLS_LIN: begin
            s_rsp.res_re    = s_re.val;
            s_rsp.res_im    = s_im.val;
            s_rsp.saturated = s_re.sat || s_im.sat;
         end
         cna_pkg::CLS_MUL: begin
            s_re = cna_pkg::sat_wide(x_mul[SW-1:cna_pkg::FRAC_W]);
            s_im = cna_pkg::sat_wide(y_mul[SW-1:cna_pkg::FRAC_W]);
            s_rsp.res_re    = s_re.val;
            s_rsp.res_im    = s_im.val;
            s_rsp.saturated = s_re.sat || s_im.sat;
         end
         cna_pkg::CLS_DIV: begin
            s_rsp.div_zero = mb == '0;
            s_div          = mb != '0;
         end
         cna_pkg::CLS_CMP: begin
            s_rsp.cmp_true = cmp;
         end
         default: begin
            s_rsp = '0;
         end
      endcase

      div_cmd.neg_re = x_div[SW-1];
      div_cmd.neg_im = y_div[SW-1];
      div_cmd.mag_re = PW'(x_div[SW-1] ? -x_div : x_div);
      div_cmd.mag_im = PW'(y_div[SW-1] ? -y_div : y_div);
      div_cmd.den    = mb;
   end

   assign div_start = adv && p_vld_ff && s_div;
   assign emit      = adv && p_vld_ff && !s_div;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_done || emit;
      end
      if (div_done) begin
         rsp_ff <= div_rsp;
      end else if (emit) begin
         rsp_ff <= s_rsp;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

[rtl/complex_number_alu_unit.sv]
// Top level of the complex number ALU: front end, item queue, back end and divider.
`timescale 1ns / 1ps
// Complex ALU on signed Q16.16 operands. Issue an item by raising start with a
// request on req_item while busy is low; the item is taken at that clock edge.
// Each item yields exactly one result, shown on rsp_item for one cycle with
// rsp_strobe high, in issue order; the receiver must take it then, as results
// cannot be held off. Add, subtract, negate, multiply and compares are taken one
// per cycle while busy is low and answer through the front register, the queue,
// the product register and the result register. A divide with a nonzero divisor
// occupies the shared radix-2 divider (one numerator split, one quotient bit per
// cycle for 32 bits, one clip step), during which the back end holds; items
// issued meanwhile wait in a 4-entry queue, and busy rises once the queue has one
// free slot left. Divide by zero answers at once with div_zero set and zeros.
module complex_number_alu_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cna_pkg::req_type req_item,
   output logic             rsp_strobe,
   output cna_pkg::rsp_type rsp_item
);

   logic                 push;
   cna_pkg::item_type    push_item;
   logic                 pop;
   logic                 q_valid;
   cna_pkg::item_type    head_item;
   logic                 almost_full;
   logic                 div_start;
   cna_pkg::div_cmd_type div_cmd;
   logic                 div_active;
   logic                 div_done;
   cna_pkg::rsp_type     div_rsp;

   // Hold off new items when the queue could not absorb the front end's item.
   assign busy = almost_full;

   cna_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .push      (push),
      .push_item (push_item)
   );

   cna_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_item   (push_item),
      .pop         (pop),
      .valid       (q_valid),
      .head_item   (head_item),
      .almost_full (almost_full)
   );

   // Execute in order; a running divide stalls the back end only.
   cna_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (head_item),
      .q_pop      (pop),
      .div_start  (div_start),
      .div_cmd    (div_cmd),
      .div_active (div_active),
      .div_done   (div_done),
      .div_rsp    (div_rsp),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   cna_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .cmd    (div_cmd),
      .active (div_active),
      .done   (div_done),
      .rsp    (div_rsp)
   );

`ifndef ASSERT_OFF
   a_div_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.div_zero |->
         rsp_item.res_re == '0 && rsp_item.res_im == '0 && !rsp_item.saturated)
      else $error("divide by zero result not cleared");
   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.cmp_true |->
         rsp_item.res_re == '0 && rsp_item.res_im == '0 && !rsp_item.div_zero)
      else $error("compare result carries arithmetic data");
`endif

endmodule
